>>> design/fixed_point_alu_macros.svh
// Assertion macros shared by the fixed-point ALU checker.
// Depends on nothing; included by the checker file.
`ifndef FIXED_POINT_ALU_MACROS_SVH
`define FIXED_POINT_ALU_MACROS_SVH
// Asserts that a condition implies another on the same edge.
`define FPA_ASSERT_IMP(lbl, clk, rstn, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
		else $error("fixed_point_alu check failed");
// Asserts that a condition implies another on the following edge.
`define FPA_ASSERT_NEXT(lbl, clk, rstn, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
		else $error("fixed_point_alu check failed");
`endif

>>> design/fpa_pkg.sv
// Package for the fixed-point ALU: opcode codes and sizing constants.
// Depends on nothing; used by fpa_div and fixed_point_alu.
`timescale 1ns / 1ps
`default_nettype none
package fpa_pkg;
	localparam int DATA_W        = 32;
	localparam int FRAC_BITS_DEF = 8;

	typedef enum logic [3:0] {
		OP_ADD      = 4'd0,
		OP_SUB      = 4'd1,
		OP_MUL      = 4'd2,
		OP_DIV      = 4'd3,
		OP_MIN      = 4'd4,
		OP_MAX      = 4'd5,
		OP_INC      = 4'd6,
		OP_DEC      = 4'd7,
		OP_TO_INT   = 4'd8,
		OP_FROM_INT = 4'd9
	} func_t;
endpackage
`default_nettype wire

>>> design/fpa_div.sv
// Pipelined restoring divider: unsigned magnitudes, one quotient bit per stage.
// Depends on fpa_pkg; instantiated by fixed_point_alu.
`timescale 1ns / 1ps
`default_nettype none
module fpa_div #(
	parameter int NUM_W = fpa_pkg::DATA_W + fpa_pkg::FRAC_BITS_DEF,
	parameter int DEN_W = fpa_pkg::DATA_W,
	parameter int TAG_W = fpa_pkg::DATA_W + 6
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	input  wire logic [TAG_W-1:0] in_tag,
	output logic                  out_valid,
	output logic [NUM_W-1:0]      quo,
	output logic [TAG_W-1:0]      out_tag
);
	import fpa_pkg::*;

	// Per-stage registers: valid, partial remainder, shifting numerator/quotient, divisor, tag.
	logic             v_s   [NUM_W];
	logic [DEN_W-1:0] rem_s [NUM_W];
	logic [NUM_W-1:0] nq_s  [NUM_W];
	logic [DEN_W-1:0] den_s [NUM_W];
	logic [TAG_W-1:0] tag_s [NUM_W];

	// One quotient bit per register stage.
	for (genvar i = 0; i < NUM_W; i++) begin : g_stage
		logic             v_i;
		logic [DEN_W-1:0] rem_i;
		logic [NUM_W-1:0] nq_i;
		logic [DEN_W-1:0] den_i;
		logic [TAG_W-1:0] tag_i;
		logic [DEN_W:0]   sh;
		logic [DEN_W:0]   diff;

		// The first stage takes the new item, later ones the stage before.
		if (i == 0) begin : g_head
			assign v_i   = in_valid;
			assign rem_i = '0;
			assign nq_i  = num;
			assign den_i = den;
			assign tag_i = in_tag;
		end else begin : g_tail
			assign v_i   = v_s[i-1];
			assign rem_i = rem_s[i-1];
			assign nq_i  = nq_s[i-1];
			assign den_i = den_s[i-1];
			assign tag_i = tag_s[i-1];
		end

		assign sh   = {rem_i, nq_i[NUM_W-1]};
		assign diff = sh - {1'b0, den_i};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else begin
				v_s[i] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (!diff[DEN_W]) begin
				rem_s[i] <= diff[DEN_W-1:0];
			end else begin
				rem_s[i] <= sh[DEN_W-1:0];
			end
			nq_s[i]  <= {nq_i[NUM_W-2:0], ~diff[DEN_W]};
			den_s[i] <= den_i;
			tag_s[i] <= tag_i;
		end
	end

	assign out_valid = v_s[NUM_W-1];
	assign quo       = nq_s[NUM_W-1];
	assign out_tag   = tag_s[NUM_W-1];
endmodule
`default_nettype wire

>>> design/fixed_point_alu.sv
// Fixed-point ALU, fully pipelined: one item accepted every cycle, busy is always low.
// Path: for every opcode, strobe is set through the input register, the operand stage, the divider's
// stage chain and the output register.
// Throughput: one item per cycle; results appear on strobe for one cycle and cannot stall.
// Reset: arst_n clears all valid bits asynchronously; payload registers are not reset.
// Depends on fpa_pkg and fpa_div.
`timescale 1ns / 1ps
`default_nettype none
module fixed_point_alu #(
	parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [3:0]         func,
	input  wire logic signed [31:0] operand_a,
	input  wire logic signed [31:0] operand_b,
	output logic                    strobe,
	output logic signed [31:0]      result,
	output logic                    a_less,
	output logic                    a_equal,
	output logic                    a_greater,
	output logic                    div_zero
);
	import fpa_pkg::*;

	localparam int NUM_W = DATA_W + FRAC_BITS;
	// Tag through the divider: result (32), flags (4), divide and negate (2).
	localparam int TAG_W = DATA_W + 6;

	assign busy = 1'b0;

	// Stage 1: register inputs.
	logic              v_s1;
	func_t             f_s1;
	logic signed [31:0] a_s1, b_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start;
		end
	end
	always_ff @(posedge clk) begin
		f_s1 <= func_t'(func);
		a_s1 <= operand_a;
		b_s1 <= operand_b;
	end

	// Stage 2: multiply, simple ops, compare, divider operand magnitudes.
	logic               lt1, eq1, gt1;
	logic [31:0]        simple1;
	assign lt1 = a_s1 < b_s1;
	assign eq1 = a_s1 == b_s1;
	assign gt1 = a_s1 > b_s1;
	always_comb begin
		case (f_s1)
			OP_ADD:      simple1 = a_s1 + b_s1;
			OP_SUB:      simple1 = a_s1 - b_s1;
			OP_MIN:      simple1 = lt1 ? a_s1 : b_s1;
			OP_MAX:      simple1 = gt1 ? a_s1 : b_s1;
			OP_INC:      simple1 = a_s1 + 32'sd1;
			OP_DEC:      simple1 = a_s1 - 32'sd1;
			OP_TO_INT:   simple1 = a_s1 >>> FRAC_BITS;
			OP_FROM_INT: simple1 = a_s1 << FRAC_BITS;
			default:     simple1 = '0;
		endcase
	end

	logic               v_s2, lt_s2, eq_s2, gt_s2, dz_s2, neg_s2, mul_s2, div_s2;
	logic [31:0]        simple_s2;
	logic signed [63:0] prod_s2;
	logic [NUM_W-1:0]   num_s2;
	logic [31:0]        den_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end
	always_ff @(posedge clk) begin
		lt_s2     <= lt1;
		eq_s2     <= eq1;
		gt_s2     <= gt1;
		simple_s2 <= simple1;
		prod_s2   <= 64'(a_s1) * 64'(b_s1);
		mul_s2    <= f_s1 == OP_MUL;
		div_s2    <= (f_s1 == OP_DIV) && (b_s1 != '0);
		dz_s2     <= (f_s1 == OP_DIV) && (b_s1 == '0);
		neg_s2    <= a_s1[31] ^ b_s1[31];
		num_s2    <= {(a_s1[31] ? 32'(-a_s1) : 32'(a_s1)), {FRAC_BITS{1'b0}}};
		den_s2    <= b_s1[31] ? 32'(-b_s1) : 32'(b_s1);
	end

	// Stage 3: select the non-divide result; the divider starts here too.
	logic [31:0] pre_res;
	logic [63:0] prod_sh;
	assign prod_sh = 64'(prod_s2 >>> FRAC_BITS);
	always_comb begin
		if (mul_s2) begin
			pre_res = prod_sh[31:0];
		end else if (dz_s2) begin
			pre_res = '0;
		end else begin
			pre_res = simple_s2;
		end
	end

	logic             dv_out;
	logic [NUM_W-1:0] quo;
	logic [TAG_W-1:0] tag_out;
	fpa_div #(.NUM_W(NUM_W), .DEN_W(DATA_W), .TAG_W(TAG_W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s2),
		.num      (num_s2),
		.den      (div_s2 ? den_s2 : 32'd1),
		.in_tag   ({pre_res, lt_s2, eq_s2, gt_s2, dz_s2, div_s2, neg_s2 & div_s2}),
		.out_valid(dv_out),
		.quo      (quo),
		.out_tag  (tag_out)
	);

	// Final stage: apply the quotient sign and register the outputs.
	logic [31:0] q32;
	assign q32 = tag_out[0] ? 32'(-quo[31:0]) : quo[31:0];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe <= 1'b0;
		end else begin
			strobe <= dv_out;
		end
	end
	always_ff @(posedge clk) begin
		result    <= tag_out[1] ? q32 : tag_out[TAG_W-1:6];
		a_less    <= tag_out[5];
		a_equal   <= tag_out[4];
		a_greater <= tag_out[3];
		div_zero  <= tag_out[2];
	end
endmodule
`default_nettype wire

>>> design/fpa_checker.sv
// Port-level checker for the fixed-point ALU, bound to the top level.
// Depends on fixed_point_alu_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "fixed_point_alu_macros.svh"
module fpa_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic busy,
	input wire logic strobe,
	input wire logic a_less,
	input wire logic a_equal,
	input wire logic a_greater,
	input wire logic div_zero,
	input wire logic signed [31:0] result
);
	`FPA_ASSERT_IMP(a_never_busy, clk, arst_n, 1'b1, !busy)
	`FPA_ASSERT_IMP(a_one_flag, clk, arst_n, strobe, $onehot({a_less, a_equal, a_greater}))
	`FPA_ASSERT_IMP(a_dz_zero, clk, arst_n, strobe && div_zero, result == 32'sd0)
	`FPA_ASSERT_IMP(a_dz_noteq, clk, arst_n, strobe && div_zero && a_equal, result == 32'sd0)
endmodule
bind fixed_point_alu fpa_checker u_fpa_checker (.*);
`default_nettype wire
